// ===== src/sod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound onset detector package
// Shared constants and register map of the sound onset detector.
// ----------------------------------------------------------------------------
package sod_pkg;

    // Default largest chunk length in samples.
    localparam int SOD_MAX_CHUNK_LEN = 1024;

    // Width of the configuration data bus and of the register address.
    localparam int SOD_DATA_W = 32;
    localparam int SOD_ADDR_W = 5;

    // Register indexes, one per 32-bit word.
    typedef enum logic [2:0] {
        REG_MIN_PEAK    = 3'd0,
        REG_MIN_MEAN    = 3'd1,
        REG_MEAN_RATIO  = 3'd2,
        REG_PEAK_RATIO  = 3'd3,
        REG_FLOOR_SHIFT = 3'd4,
        REG_COOLDOWN    = 3'd5,
        REG_SETTLE      = 3'd6
    } t_reg_idx;

    // Register values after reset.
    localparam logic [15:0] RST_MIN_PEAK    = 16'd12000;
    localparam logic [15:0] RST_MIN_MEAN    = 16'd1800;
    localparam logic [15:0] RST_MEAN_RATIO  = 16'd350;
    localparam logic [15:0] RST_PEAK_RATIO  = 16'd700;
    localparam logic [3:0]  RST_FLOOR_SHIFT = 4'd4;
    localparam logic [15:0] RST_COOLDOWN    = 16'd500;
    localparam logic [15:0] RST_SETTLE      = 16'd100;

    // Ratio thresholds are given in hundredths.
    localparam logic [15:0] RATIO_SCALE = 16'd100;

    // Saturation value of the settle counter.
    localparam logic [15:0] SETTLE_SAT = 16'hFFFF;

endpackage

// ===== src/sound_onset_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound onset detector
// Tracks peak and mean magnitude per chunk of audio samples, follows a noise
// floor and flags chunks that rise well above it.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Word
//  -------   -----------------------   -------------------------------------
//  input     i_in_valid / o_in_stall   i_sample, i_last
//  output    o_out_valid / i_out_stall o_peak_mag, o_mean_mag, o_floor_level,
//                                      o_event_res
//  config    psel/penable/pwrite       paddr, pwdata, prdata (pready high)
//
// A sample that does not end its chunk leaves the input open for the next
// sample. A chunk-ending sample runs the sequencer in order: S_DIV forms the
// mean on the restoring divider, one bit per cycle, S_FLOOR updates the floor,
// S_MUL runs the shared 16x16 multiplier for the two ratio tests, and S_OUT
// loads the result.
// Reset is synchronous and active low; it loads the register defaults.
// The next chunk is accepted while a finished word waits on the output; a
// chunk end that finds the output still full waits for it to drain.
//
module sound_onset_detector
    import sod_pkg::*;
#(
    parameter int MAX_CHUNK_LEN = SOD_MAX_CHUNK_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_sample,
    input  logic                  i_last,
    // Result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_peak_mag,
    output logic [15:0]           o_mean_mag,
    output logic [15:0]           o_floor_level,
    output logic                  o_event_res,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [SOD_ADDR_W-1:0] paddr,
    input  logic [SOD_DATA_W-1:0] pwdata,
    output logic [SOD_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Widths that follow from the chunk length.
    localparam int CNT_W  = $clog2(MAX_CHUNK_LEN + 1);
    localparam int SUM_W  = $clog2(64'(MAX_CHUNK_LEN) * 64'd32768 + 64'd1);
    localparam int ITER_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FLOOR,
        S_MUL,
        S_OUT
    } t_state;

    // Configuration registers.
    logic [15:0] r_min_peak;
    logic [15:0] r_min_mean;
    logic [15:0] r_mean_ratio;
    logic [15:0] r_peak_ratio;
    logic [3:0]  r_floor_shift;
    logic [15:0] r_cooldown;
    logic [15:0] r_settle;

    // Sequencer and detector state.
    t_state          r_state;
    logic [15:0]     r_chunk_peak;
    logic [SUM_W-1:0] r_chunk_sum;
    logic [CNT_W-1:0] r_chunk_count;
    logic [15:0]     r_floor;
    logic            r_floor_valid;
    logic [15:0]     r_chunks_counted;
    logic [15:0]     r_hold_off;
    logic            r_out_valid;

    // Working registers of the shared units.
    logic [15:0]      r_peak_res;
    logic [15:0]      r_mean;
    logic [SUM_W-1:0] r_quot;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_divisor;
    logic [ITER_W-1:0] r_iter;
    logic [2:0]       r_mul_step;
    logic [31:0]      r_prod;
    logic [31:0]      r_lhs;
    logic             r_mean_rise;
    logic             r_peak_rise;

    // Output word registers.
    logic [15:0] r_out_peak;
    logic [15:0] r_out_mean;
    logic [15:0] r_out_floor;
    logic        r_out_event;

    // Combinational helpers.
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;
    logic             w_accept;
    logic [15:0]      w_mag;
    logic [15:0]      w_peak_new;
    logic [SUM_W-1:0] w_sum_new;
    logic [CNT_W-1:0] w_cnt_new;
    logic             w_chunk_end;
    logic [CNT_W:0]   w_rem_sh;
    logic             w_div_bit;
    logic [15:0]      w_quot_mean;
    logic [15:0]      w_floor_up;
    logic [15:0]      w_diff_dn;
    logic [16:0]      w_step_dn;
    logic [15:0]      w_nf;
    logic [15:0]      w_mul_a;
    logic [15:0]      w_mul_b;
    logic             w_eligible;
    logic             w_loud;
    logic             w_event;
    logic             w_out_free;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_reg_idx   = t_reg_idx'(paddr[4:2]);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_MIN_PEAK:    prdata = SOD_DATA_W'(r_min_peak);
            REG_MIN_MEAN:    prdata = SOD_DATA_W'(r_min_mean);
            REG_MEAN_RATIO:  prdata = SOD_DATA_W'(r_mean_ratio);
            REG_PEAK_RATIO:  prdata = SOD_DATA_W'(r_peak_ratio);
            REG_FLOOR_SHIFT: prdata = SOD_DATA_W'(r_floor_shift);
            REG_COOLDOWN:    prdata = SOD_DATA_W'(r_cooldown);
            REG_SETTLE:      prdata = SOD_DATA_W'(r_settle);
            default:         prdata = '0;
        endcase
    end

    // Sample magnitude and chunk accumulation; the most negative sample gives 32768.
    always_comb begin
        w_mag       = i_sample[15] ? 16'(~i_sample + 16'sd1) : 16'(i_sample);
        w_peak_new  = (w_mag > r_chunk_peak) ? w_mag : r_chunk_peak;
        w_sum_new   = r_chunk_sum + SUM_W'(w_mag);
        w_cnt_new   = r_chunk_count + CNT_W'(1);
        w_chunk_end = i_last || (w_cnt_new == CNT_W'(MAX_CHUNK_LEN));
    end

    // One step of the restoring divider.
    always_comb begin
        w_rem_sh  = {r_rem, r_quot[SUM_W-1]};
        w_div_bit = (w_rem_sh >= {1'b0, r_divisor});
    end

    // Noise floor moves: up rounds down, down rounds away from the floor.
    always_comb begin
        w_quot_mean = r_quot[15:0];
        w_floor_up  = r_floor + ((w_quot_mean - r_floor) >> r_floor_shift);
        w_diff_dn   = r_floor - w_quot_mean;
        w_step_dn   = ({1'b0, w_diff_dn} + ((17'd1 << r_floor_shift) - 17'd1))
                      >> r_floor_shift;
    end

    // Operand select of the shared multiplier.
    always_comb begin
        w_nf = (r_floor > 16'd1) ? r_floor : 16'd1;
        case (r_mul_step)
            3'd0:    begin w_mul_a = r_mean;     w_mul_b = RATIO_SCALE;  end
            3'd1:    begin w_mul_a = w_nf;       w_mul_b = r_mean_ratio; end
            3'd2:    begin w_mul_a = r_peak_res; w_mul_b = RATIO_SCALE;  end
            3'd3:    begin w_mul_a = w_nf;       w_mul_b = r_peak_ratio; end
            default: begin w_mul_a = '0;         w_mul_b = '0;           end
        endcase
    end

    // Event decision on the updated floor, settle count and cooldown.
    always_comb begin
        w_eligible = (r_chunks_counted >= r_settle) && (r_hold_off == 16'd0);
        w_loud     = (r_peak_res >= r_min_peak) && (r_mean >= r_min_mean);
        w_event    = w_eligible && w_loud && r_mean_rise && r_peak_rise;
    end

    // Sequencer, detector state and output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_peak       <= RST_MIN_PEAK;
            r_min_mean       <= RST_MIN_MEAN;
            r_mean_ratio     <= RST_MEAN_RATIO;
            r_peak_ratio     <= RST_PEAK_RATIO;
            r_floor_shift    <= RST_FLOOR_SHIFT;
            r_cooldown       <= RST_COOLDOWN;
            r_settle         <= RST_SETTLE;
            r_state          <= S_IDLE;
            r_chunk_peak     <= '0;
            r_chunk_sum      <= '0;
            r_chunk_count    <= '0;
            r_floor          <= '0;
            r_floor_valid    <= 1'b0;
            r_chunks_counted <= '0;
            r_hold_off       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            // Configuration writes.
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    REG_MIN_PEAK:    r_min_peak    <= pwdata[15:0];
                    REG_MIN_MEAN:    r_min_mean    <= pwdata[15:0];
                    REG_MEAN_RATIO:  r_mean_ratio  <= pwdata[15:0];
                    REG_PEAK_RATIO:  r_peak_ratio  <= pwdata[15:0];
                    REG_FLOOR_SHIFT: r_floor_shift <= pwdata[3:0];
                    REG_COOLDOWN:    r_cooldown    <= pwdata[15:0];
                    REG_SETTLE:      r_settle      <= pwdata[15:0];
                    default:         ;
                endcase
            end

            // A new word is loaded by the last sequencer step; otherwise the
            // output word leaves when the far side takes it.
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_chunk_end) begin
                            r_peak_res    <= w_peak_new;
                            r_quot        <= w_sum_new;
                            r_divisor     <= w_cnt_new;
                            r_rem         <= '0;
                            r_iter        <= ITER_W'(SUM_W - 1);
                            r_chunk_peak  <= '0;
                            r_chunk_sum   <= '0;
                            r_chunk_count <= '0;
                            if (r_chunks_counted != SETTLE_SAT) begin
                                r_chunks_counted <= r_chunks_counted + 16'd1;
                            end
                            r_state <= S_DIV;
                        end else begin
                            r_chunk_peak  <= w_peak_new;
                            r_chunk_sum   <= w_sum_new;
                            r_chunk_count <= w_cnt_new;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_div_bit ? CNT_W'(w_rem_sh - {1'b0, r_divisor})
                                        : CNT_W'(w_rem_sh);
                    r_quot <= {r_quot[SUM_W-2:0], w_div_bit};
                    r_iter <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_state <= S_FLOOR;
                    end
                end
                S_FLOOR: begin
                    r_mean <= w_quot_mean;
                    if (!r_floor_valid) begin
                        r_floor       <= w_quot_mean;
                        r_floor_valid <= 1'b1;
                    end else if (r_hold_off == 16'd0) begin
                        if (w_quot_mean >= r_floor) begin
                            r_floor <= w_floor_up;
                        end else begin
                            r_floor <= r_floor - w_step_dn[15:0];
                        end
                    end
                    if (r_hold_off != 16'd0) begin
                        r_hold_off <= r_hold_off - 16'd1;
                    end
                    r_mul_step <= 3'd0;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    // Each product is registered before it is compared.
                    r_prod     <= w_mul_a * w_mul_b;
                    r_lhs      <= r_prod;
                    r_mul_step <= r_mul_step + 3'd1;
                    if (r_mul_step == 3'd2) begin
                        r_mean_rise <= (r_lhs >= r_prod);
                    end
                    if (r_mul_step == 3'd4) begin
                        r_peak_rise <= (r_lhs >= r_prod);
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_peak  <= r_peak_res;
                        r_out_mean  <= r_mean;
                        r_out_floor <= r_floor;
                        r_out_event <= w_event;
                        if (w_event) begin
                            r_hold_off <= r_cooldown;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_peak_mag    = r_out_peak;
    assign o_mean_mag    = r_out_mean;
    assign o_floor_level = r_out_floor;
    assign o_event_res   = r_out_event;

`ifndef SYNTHESIS
    // A running chunk is always shorter than the largest chunk.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_count < CNT_W'(MAX_CHUNK_LEN))
        else $error("chunk count reached the chunk limit");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_divisor != '0))
        else $error("divide started with zero sample count");

    // The mean of 16-bit magnitudes stays within 32768.
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLOOR) |-> (r_quot <= SUM_W'(32768)))
        else $error("chunk mean out of range");

    // A new output word only comes from the load step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output word raised outside the load step");

    // Before the first chunk completes, no chunk has been counted.
    a_floor_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_floor_valid && r_state == S_IDLE) |-> (r_chunks_counted == 16'd0))
        else $error("floor not seeded after a counted chunk");
`endif

endmodule
